[rtl/core/mi4_pkg.sv]
// ============================================================================
// mi4_pkg
// Shared types, state encodings and minor-address helpers for the 4x4
// matrix inverse block.
// ============================================================================
package mi4_pkg;

    localparam int MAT_N = 16;
    localparam int IDX_W = 4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RA,
        ST_RB,
        ST_RC,
        ST_MAB,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_CWR,
        ST_DRD,
        ST_DLD,
        ST_DMUL,
        ST_DADD,
        ST_DSUM,
        ST_DABS,
        ST_DSAT,
        ST_QRD,
        ST_QLD,
        ST_QWAIT
    } top_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_ITER,
        DV_FIN
    } div_state_t;

    typedef struct packed {
        logic start;
        logic num_neg;
        logic den_neg;
    } div_ctl_t;

    function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] fact);
        logic [5:0] p;
        case (term)
            3'd0:    p = {2'd0, 2'd1, 2'd2};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd1, 2'd2, 2'd0};
            3'd4:    p = {2'd2, 2'd0, 2'd1};
            3'd5:    p = {2'd2, 2'd1, 2'd0};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        case (fact)
            2'd0:    return p[5:4];
            2'd1:    return p[3:2];
            default: return p[1:0];
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] minor_addr(input logic [IDX_W-1:0] cof,
                                                   input logic [2:0] term,
                                                   input logic [1:0] fact);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] p;
        r = (fact >= cof[3:2]) ? fact + 2'd1 : fact;
        p = perm_col(term, fact);
        c = (p >= cof[1:0]) ? p + 2'd1 : p;
        return {r, c};
    endfunction

    function automatic logic term_is_neg(input logic [2:0] term);
        return term inside {3'd1, 3'd2, 3'd5};
    endfunction

endpackage

[rtl/core/mi4_mem.sv]
// ============================================================================
// mi4_mem
// Sixteen-entry synchronous RAM, one write port, one registered read port.
// ============================================================================
module mi4_mem
    import mi4_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [W-1:0]         wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [MAT_N];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/mi4_div.sv]
// ============================================================================
// mi4_div
// Restoring divider, one quotient bit per cycle, with saturation of the
// signed quotient to EW bits.
// ============================================================================
module mi4_div
    import mi4_pkg::*;
#(
    parameter int EW = 32,
    parameter int NW = 129,
    parameter int DW = 130
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctl_t             ctl,
    input  logic [NW-1:0]        num_mag,
    input  logic [DW-1:0]        den_mag,
    output logic                 done,
    output logic signed [EW-1:0] quot
);

    localparam int RA_W  = NW - EW - 1;
    localparam int RW    = (DW + 1 > RA_W) ? DW + 1 : RA_W;
    localparam int CNT_W = $clog2(EW + 1);
    localparam logic [EW:0] QLIM = (EW+1)'(1) << (EW - 1);

    div_state_t          state_reg, state_next;
    logic [RW-1:0]       rem_reg;
    logic [EW:0]         nbits_reg;
    logic [EW:0]         q_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                big_reg;
    logic                neg_reg;
    logic                done_reg;
    logic signed [EW-1:0] quot_reg;

    logic [RW-1:0]       den_x;
    logic [RW-1:0]       rsh;
    logic                ge;
    logic signed [EW-1:0] sat_val;

    assign den_x = RW'(den_mag);
    assign rsh   = {rem_reg[RW-2:0], nbits_reg[EW]};
    assign ge    = rsh >= den_x;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:  if (ctl.start) state_next = DV_CHECK;
            DV_CHECK: state_next = (rem_reg >= den_x) ? DV_FIN : DV_ITER;
            DV_ITER:  if (cnt_reg == CNT_W'(EW)) state_next = DV_FIN;
            DV_FIN:   state_next = DV_IDLE;
            default:  state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (big_reg || q_reg > QLIM)
                sat_val = {1'b1, {(EW-1){1'b0}}};
            else
                sat_val = EW'(0) - q_reg[EW-1:0];
        end
        else
        begin
            if (big_reg || q_reg >= QLIM)
                sat_val = {1'b0, {(EW-1){1'b1}}};
            else
                sat_val = q_reg[EW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DV_FIN);
            if (state_reg == DV_CHECK)
                cnt_reg <= '0;
            else if (state_reg == DV_ITER)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (ctl.start)
                begin
                    rem_reg   <= RW'(num_mag[NW-1:EW+1]);
                    nbits_reg <= num_mag[EW:0];
                    neg_reg   <= ctl.num_neg ^ ctl.den_neg;
                end
            end
            DV_CHECK:
            begin
                big_reg <= rem_reg >= den_x;
                q_reg   <= '0;
            end
            DV_ITER:
            begin
                rem_reg   <= ge ? rsh - den_x : rsh;
                q_reg     <= {q_reg[EW-1:0], ge};
                nbits_reg <= nbits_reg << 1;
            end
            DV_FIN:
            begin
                quot_reg <= sat_val;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/core/matrix_inverse_4x4.sv]
// ============================================================================
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by cofactor expansion and adjugate.
// ============================================================================
// Usage: load elements with start high while busy is low, one item per
// cycle, each with its row-major element_index. The item with load_last set
// is stored and then starts an inversion; busy stays high until the
// sixteenth result has been given. Elements not rewritten keep their value.
// Results come out in index order, each on result_valid for one cycle, with
// determinant (Q32.32, saturated) and singular held across the run and
// result_last on the sixteenth. The receiver cannot stall.
// Each of the 16 cofactors sums 6 triple products, each read from the
// element store, multiplied and accumulated, and is then written to the
// cofactor store; the determinant follows from row 0, then each result
// is a division in the one-bit-per-cycle divider (zero, no division, when
// singular). The element store and the cofactor store are synchronous
// RAMs with one write and one read port; one divider serves all results.
// Reset returns the sequencer to idle and clears the reported determinant;
// elements not written since reset read as zero.
// ============================================================================
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic               load_last,
    output logic               result_valid,
    output logic [3:0]         result_index,
    output logic signed [31:0] result_value,
    output logic signed [63:0] determinant,
    output logic               singular,
    output logic               result_last
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int PW  = 2 * EW;
    localparam int CW  = 3 * EW + 1;
    localparam int NCH = (CW + EW - 1) / EW;
    localparam int CHW = $clog2(NCH);
    localparam int CXW = NCH * EW;
    localparam int DW  = 4 * EW + 2;
    localparam int NW  = CW + 2 * FB;
    localparam int TW  = DW - 2 * FB;
    localparam int XW  = (TW > 65) ? TW : 65;

    top_state_t state_reg, state_next;

    logic [IDX_W-1:0]       cof_reg;
    logic [2:0]             term_reg;
    logic [1:0]             j_reg;
    logic [CHW-1:0]         chunk_reg;
    logic [IDX_W-1:0]       out_reg;

    logic signed [EW-1:0]   fa_reg, fb_reg, fc_reg;
    logic signed [PW-1:0]   pab_reg;
    logic signed [PW:0]     plo_reg;
    logic signed [PW-1:0]   phi_reg;
    logic signed [CW-1:0]   acc_reg;
    logic [CXW-1:0]         creg_reg;
    logic signed [EW-1:0]   ereg_reg;
    logic signed [PW:0]     prod_reg;
    logic signed [DW-1:0]   pj_reg;
    logic signed [DW-1:0]   det_reg;
    logic [DW-1:0]          dmag_reg;
    logic                   sing_reg;
    logic                   dneg_reg;
    logic signed [63:0]     det_out_reg;
    logic [MAT_N-1:0]       mvld_reg;
    logic                   mvld_rd_reg;

    logic                   valid_reg;
    logic [IDX_W-1:0]       rindex_reg;
    logic signed [31:0]     rvalue_reg;
    logic                   rlast_reg;

    logic                   accept;
    logic [IDX_W-1:0]       mat_raddr;
    logic [EW-1:0]          mat_rdata;
    logic [EW-1:0]          mat_q;
    logic                   cof_we;
    logic [IDX_W-1:0]       cof_raddr;
    logic [CW-1:0]          cof_wdata;
    logic [CW-1:0]          cof_rdata;
    div_ctl_t               div_ctl;
    logic [NW-1:0]          num_mag;
    logic                   div_done;
    logic signed [EW-1:0]   div_quot;
    logic                   emit;

    logic signed [CW-1:0]   tsum;
    logic [EW-1:0]          top_chunk;
    logic signed [EW:0]     chunk_op;
    logic signed [CW-1:0]   cval;
    logic [CW-1:0]          cmag;
    logic [XW-1:0]          tx;
    logic [XW-1:0]          tlim;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    mi4_mem #(.W(EW)) u_mat (
        .clk   (clk),
        .we    (accept),
        .waddr (element_index),
        .wdata (element_value[EW-1:0]),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mi4_mem #(.W(CW)) u_cof (
        .clk   (clk),
        .we    (cof_we),
        .waddr (cof_reg),
        .wdata (cof_wdata),
        .raddr (cof_raddr),
        .rdata (cof_rdata)
    );

    mi4_div #(.EW(EW), .NW(NW), .DW(DW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .num_mag (num_mag),
        .den_mag (dmag_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign mat_q     = mvld_rd_reg ? mat_rdata : '0;
    assign tsum      = (CW'(phi_reg) <<< EW) + CW'(plo_reg);
    assign top_chunk = creg_reg[CXW-1 -: EW];
    assign chunk_op  = (chunk_reg == '0) ? $signed({top_chunk[EW-1], top_chunk})
                                         : $signed({1'b0, top_chunk});
    assign cval      = $signed(cof_rdata);
    assign cmag      = cval[CW-1] ? CW'(-cval) : CW'(cval);
    assign num_mag   = {cmag, {(2*FB){1'b0}}};
    assign tx        = XW'(dmag_reg[DW-1:2*FB]);
    assign tlim      = XW'({1'b1, 63'b0});
    assign emit      = ((state_reg == ST_QLD) && sing_reg)
                       || ((state_reg == ST_QWAIT) && div_done);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && load_last) state_next = ST_RA;
            ST_RA:    state_next = ST_RB;
            ST_RB:    state_next = ST_RC;
            ST_RC:    state_next = ST_MAB;
            ST_MAB:   state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_ACC;
            ST_ACC:   state_next = (term_reg == 3'd5) ? ST_CWR : ST_RA;
            ST_CWR:   state_next = (cof_reg == 4'd15) ? ST_DRD : ST_RA;
            ST_DRD:   state_next = ST_DLD;
            ST_DLD:   state_next = ST_DMUL;
            ST_DMUL:  state_next = ST_DADD;
            ST_DADD:  state_next = (chunk_reg == CHW'(NCH - 1)) ? ST_DSUM : ST_DMUL;
            ST_DSUM:  state_next = (j_reg == 2'd3) ? ST_DABS : ST_DRD;
            ST_DABS:  state_next = ST_DSAT;
            ST_DSAT:  state_next = ST_QRD;
            ST_QRD:   state_next = ST_QLD;
            ST_QLD:
            begin
                if (sing_reg)
                    state_next = (out_reg == 4'd15) ? ST_IDLE : ST_QRD;
                else
                    state_next = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                if (div_done)
                    state_next = (out_reg == 4'd15) ? ST_IDLE : ST_QRD;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mat_raddr       = '0;
        cof_raddr       = '0;
        cof_we          = 1'b0;
        cof_wdata       = (cof_reg[2] ^ cof_reg[0]) ? CW'(-acc_reg) : CW'(acc_reg);
        div_ctl.start   = 1'b0;
        div_ctl.num_neg = cval[CW-1];
        div_ctl.den_neg = dneg_reg;
        case (state_reg)
            ST_RA:   mat_raddr = minor_addr(cof_reg, term_reg, 2'd0);
            ST_RB:   mat_raddr = minor_addr(cof_reg, term_reg, 2'd1);
            ST_RC:   mat_raddr = minor_addr(cof_reg, term_reg, 2'd2);
            ST_CWR:  cof_we = 1'b1;
            ST_DRD:
            begin
                mat_raddr = {2'b00, j_reg};
                cof_raddr = {2'b00, j_reg};
            end
            ST_QRD:  cof_raddr = {out_reg[1:0], out_reg[3:2]};
            ST_QLD:  div_ctl.start = !sing_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg    <= '0;
            mvld_rd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                mvld_reg[element_index] <= 1'b1;
            mvld_rd_reg <= mvld_reg[mat_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cof_reg     <= '0;
            term_reg    <= '0;
            j_reg       <= '0;
            chunk_reg   <= '0;
            out_reg     <= '0;
            valid_reg   <= 1'b0;
            rlast_reg   <= 1'b0;
            sing_reg    <= 1'b0;
            det_out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= emit;
            rlast_reg <= emit && (out_reg == 4'd15);
            case (state_reg)
                ST_IDLE:
                begin
                    cof_reg  <= '0;
                    term_reg <= '0;
                    j_reg    <= '0;
                    out_reg  <= '0;
                end
                ST_ACC:  term_reg <= (term_reg == 3'd5) ? 3'd0 : term_reg + 3'd1;
                ST_CWR:  cof_reg <= cof_reg + 4'd1;
                ST_DLD:  chunk_reg <= '0;
                ST_DADD: chunk_reg <= chunk_reg + CHW'(1);
                ST_DSUM: j_reg <= j_reg + 2'd1;
                ST_DABS: sing_reg <= (det_reg == '0);
                ST_DSAT:
                begin
                    if (!dneg_reg)
                        det_out_reg <= (tx >= tlim) ? {1'b0, {63{1'b1}}} : tx[63:0];
                    else
                        det_out_reg <= (tx > tlim) ? {1'b1, 63'b0} : 64'(64'd0 - tx[63:0]);
                end
                ST_QLD:
                begin
                    if (sing_reg)
                    begin
                        rindex_reg <= out_reg;
                        rvalue_reg <= '0;
                        out_reg    <= out_reg + 4'd1;
                    end
                end
                ST_QWAIT:
                begin
                    if (div_done)
                    begin
                        rindex_reg <= out_reg;
                        rvalue_reg <= 32'(div_quot);
                        out_reg    <= out_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                acc_reg <= '0;
                det_reg <= '0;
            end
            ST_RB:   fa_reg  <= $signed(mat_q);
            ST_RC:   fb_reg  <= $signed(mat_q);
            ST_MAB:
            begin
                fc_reg  <= $signed(mat_q);
                pab_reg <= fa_reg * fb_reg;
            end
            ST_MLO:  plo_reg <= $signed({1'b0, pab_reg[EW-1:0]}) * fc_reg;
            ST_MHI:  phi_reg <= $signed(pab_reg[PW-1:EW]) * fc_reg;
            ST_ACC:  acc_reg <= term_is_neg(term_reg) ? acc_reg - tsum : acc_reg + tsum;
            ST_CWR:  acc_reg <= '0;
            ST_DLD:
            begin
                creg_reg <= CXW'(cval);
                ereg_reg <= $signed(mat_q);
                pj_reg   <= '0;
            end
            ST_DMUL:
            begin
                prod_reg <= chunk_op * ereg_reg;
                creg_reg <= creg_reg << EW;
            end
            ST_DADD: pj_reg  <= (pj_reg <<< EW) + DW'(prod_reg);
            ST_DSUM: det_reg <= det_reg + pj_reg;
            ST_DABS:
            begin
                dneg_reg <= det_reg[DW-1];
                dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = valid_reg;
    assign result_index = rindex_reg;
    assign result_value = rvalue_reg;
    assign result_last  = rlast_reg;
    assign determinant  = det_out_reg;
    assign singular     = sing_reg;

endmodule

[tb/matrix_inverse_4x4_tb.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_tb
// Self-checking testbench for the 4x4 fixed-point matrix inverse. Elements are
// loaded through the start/busy handshake. Every matrix closed by a last
// element is inverted by a wide-integer adjugate predictor, and its sixteen
// results are compared in order against the block's result strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix_inverse_4x4_tb;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               last;
        logic               drain;
    } element_item_t;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic signed [63:0] det;
        logic               sing;
        logic               last;
    } inverse_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               load_last;
    logic               result_valid;
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic signed [63:0] determinant;
    logic               singular;
    logic               result_last;

    element_item_t   pending_elements[$];
    inverse_result_t inverse_expect[$];
    logic signed [31:0] element_copy[16];
    int  items_sent;
    int  idle_pct;
    bit  taken;
    bit  failed;

    matrix_inverse_4x4 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element_index(element_index),
        .element_value(element_value),
        .load_last    (load_last),
        .result_valid (result_valid),
        .result_index (result_index),
        .result_value (result_value),
        .determinant  (determinant),
        .singular     (singular),
        .result_last  (result_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic wide_t stored(int r, int c);
        wide_t v;
        v = element_copy[r * 4 + c];
        return v;
    endfunction

    function automatic wide_t cofactor_of(int row, int col);
        int    rs[3];
        int    cs[3];
        int    n;
        wide_t a, b, c, d, e, f, g, h, k, m;
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != row)
            begin
                rs[n] = i;
                n++;
            end
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != col)
            begin
                cs[n] = i;
                n++;
            end
        a = stored(rs[0], cs[0]); b = stored(rs[0], cs[1]); c = stored(rs[0], cs[2]);
        d = stored(rs[1], cs[0]); e = stored(rs[1], cs[1]); f = stored(rs[1], cs[2]);
        g = stored(rs[2], cs[0]); h = stored(rs[2], cs[1]); k = stored(rs[2], cs[2]);
        m = a * (e * k - f * h) - b * (d * k - f * g) + c * (d * h - e * g);
        return ((row + col) % 2) ? -m : m;
    endfunction

    function automatic logic signed [63:0] saturate(wide_t v, int bits);
        wide_t lim;
        lim = 192'sd1 <<< (bits - 1);
        if (v >= lim)
            v = lim - 1;
        else if (v < -lim)
            v = -lim;
        return v[63:0];
    endfunction

    task automatic predict_inverse();
        wide_t           cof[16];
        wide_t           det, num;
        inverse_result_t res;
        det = 0;
        for (int p = 0; p < 16; p++)
            cof[p] = cofactor_of(p / 4, p % 4);
        for (int j = 0; j < 4; j++)
            det = det + stored(0, j) * cof[j];
        res.sing = (det == 0);
        res.det  = saturate(det / 192'sh1_0000_0000, 64);
        for (int p = 0; p < 16; p++)
        begin
            res.index = p[3:0];
            res.last  = (p == 15);
            res.value = 0;
            if (!res.sing)
            begin
                num = cof[(p % 4) * 4 + p / 4] <<< 32;
                res.value = 32'(saturate(num / det, 32));
            end
            inverse_expect.push_back(res);
        end
    endtask

    // accept items and check results
    always @(posedge clk)
    begin
        taken = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken = 1'b1;
                element_copy[element_index] = element_value;
                if (load_last)
                    predict_inverse();
            end
            if (result_valid)
            begin
                if (inverse_expect.size() == 0)
                begin
                    $error("unexpected result index %0d", result_index);
                    failed = 1'b1;
                end
                else
                begin
                    inverse_result_t x;
                    x = inverse_expect.pop_front();
                    if (result_index !== x.index)
                    begin
                        $error("result_index exp %0d got %0d", x.index, result_index);
                        failed = 1'b1;
                    end
                    if (result_value !== x.value)
                    begin
                        $error("result_value exp %0h got %0h", x.value, result_value);
                        failed = 1'b1;
                    end
                    if (determinant !== x.det)
                    begin
                        $error("determinant exp %0h got %0h", x.det, determinant);
                        failed = 1'b1;
                    end
                    if (singular !== x.sing)
                    begin
                        $error("singular exp %0b got %0b", x.sing, singular);
                        failed = 1'b1;
                    end
                    if (result_last !== x.last)
                    begin
                        $error("result_last exp %0b got %0b", x.last, result_last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // drive items at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !(start && !taken))
        begin
            if (taken)
                items_sent++;
            idle_pct = (items_sent < 80) ? 33 : (items_sent < 160) ? 51 : 0;
            if (pending_elements.size() == 0
                || (pending_elements[0].drain && inverse_expect.size() != 0)
                || $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                element_item_t it;
                it = pending_elements.pop_front();
                start         <= 1'b1;
                element_index <= it.index;
                element_value <= it.value;
                load_last     <= it.last;
            end
        end
    end

    function automatic logic signed [31:0] random_element(int kind);
        case (kind)
            0:       return $signed($urandom_range(524287)) - 262144;
            1:       return $urandom;
            2:       return ($signed($urandom_range(16)) - 8) <<< 16;
            default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    task automatic add_element(int idx, logic signed [31:0] v, bit last, bit drain);
        element_item_t it;
        it.index = idx[3:0];
        it.value = v;
        it.last  = last;
        it.drain = drain;
        pending_elements.push_back(it);
    endtask

    initial
    begin
        int kind;
        int n;
        int total;
        rst_n         = 1'b0;
        start         = 1'b0;
        element_index = '0;
        element_value = '0;
        load_last     = 1'b0;
        items_sent    = 0;
        failed        = 1'b0;
        taken         = 1'b0;
        for (int p = 0; p < 16; p++)
            element_copy[p] = 0;

        // identity, then singular, tiny determinant, saturating entries
        for (int p = 0; p < 16; p++)
            add_element(p, (p % 5 == 0) ? 32'sh0001_0000 : 32'sh0, p == 15, 1'b0);
        add_element(5, 32'sh0, 1'b1, 1'b0);
        add_element(0, 32'sh1, 1'b0, 1'b0);
        add_element(5, 32'sh1, 1'b0, 1'b0);
        add_element(10, 32'sh1, 1'b0, 1'b0);
        add_element(15, 32'sh1, 1'b1, 1'b0);
        add_element(0, 32'sh7fff_ffff, 1'b0, 1'b1);
        add_element(15, 32'sh8000_0000, 1'b1, 1'b0);
        total = 23;

        while (total < 230)
        begin
            kind = $urandom_range(3);
            if ($urandom_range(99) < 60)
            begin
                for (int p = 0; p < 16; p++)
                    add_element(p, random_element($urandom_range(9) == 0 ? 3 : kind),
                                p == 15, p == 0 && $urandom_range(7) == 0);
                total += 16;
            end
            else
            begin
                n = $urandom_range(5);
                for (int p = 0; p <= n; p++)
                    add_element($urandom_range(15), random_element(kind), p == n, 1'b0);
                total += n + 1;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_elements.size() != 0 || start || inverse_expect.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (!failed)
            $display("[matrix_inverse_4x4] OK");
        else
            $display("[matrix_inverse_4x4] ERROR");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("[matrix_inverse_4x4] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/mi4_pkg.sv
rtl/core/mi4_mem.sv
rtl/core/mi4_div.sv
rtl/core/matrix_inverse_4x4.sv
tb/matrix_inverse_4x4_tb.sv
